@@ hdl/tpm_pkg.sv @@
// Shared types and constants for the timestamp pair matcher.
// No dependencies; every other file of the block imports this package.
package tpm_pkg;

    localparam int STAMP_W = 63;
    localparam int TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Operation applied to one window in the update cycle
    typedef enum logic [1:0] {
        WIN_HOLD   = 2'd0,
        WIN_REMOVE = 2'd1,
        WIN_APPEND = 2'd2
    } win_op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

    // Window to datapath, valid in the update cycle
    typedef struct packed {
        logic hit;
        logic drop;
    } win_stat_t;

endpackage

@@ hdl/tpm_window.sv @@
// One side's age-ordered stamp window with pending marks and match vectors.
// Depends on tpm_pkg.
module tpm_window
    import tpm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capture,
    input  logic [STAMP_W-1:0] stamp_in,
    input  logic [STAMP_W-1:0] stamp_hold,
    input  win_op_t            op,
    output win_stat_t          stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [STAMP_W-1:0] st_reg [DEPTH];
    logic [STAMP_W-1:0] st_next [DEPTH];
    logic [STAMP_W-1:0] st_up [DEPTH];
    logic [DEPTH-1:0]   pd_reg, pd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DEPTH-1:0]   eq_s_reg, eq_0_reg;
    logic               new0_reg;

    logic [DEPTH-1:0]   valid;
    logic [DEPTH-1:0]   hit_vec, pend0, from_low, pd_clr, pd_ev;
    logic               hit, fresh, new_hit0, full;

    // entries below the fill count are live
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid[i] = CNT_W'(i) < count_reg;
        end
    end

    // compare the arriving stamp, and the oldest stamp, against every entry
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                eq_s_reg[i] <= valid[i] && (st_reg[i] == stamp_in);
                eq_0_reg[i] <= valid[i] && (st_reg[i] == st_reg[0]);
            end
            new0_reg <= (stamp_in == st_reg[0]);
        end
    end

    always_comb
    begin
        hit_vec  = eq_s_reg & pd_reg;
        hit      = |hit_vec;
        fresh    = !hit;
        pend0    = eq_0_reg & pd_reg;
        new_hit0 = fresh && new0_reg;
        full     = (count_reg == CNT_W'(DEPTH));
        // ones from the oldest matching entry upward
        from_low = eq_s_reg | (~eq_s_reg + DEPTH'(1));
        pd_clr   = pd_reg & ~hit_vec;
        pd_ev    = (pd_reg & ~pend0) >> 1;
        pd_ev[DEPTH-1] = fresh && !new_hit0;

        for (int i = 0; i < DEPTH - 1; i++)
        begin
            st_up[i] = st_reg[i+1];
        end
        st_up[DEPTH-1] = stamp_hold;

        st_next    = st_reg;
        pd_next    = pd_reg;
        count_next = count_reg;

        unique case (op)
            WIN_HOLD:
            begin
            end
            WIN_REMOVE:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (from_low[i])
                    begin
                        st_next[i] = st_up[i];
                    end
                end
                pd_next    = (pd_clr & ~from_low) | ((pd_clr >> 1) & from_low);
                count_next = count_reg - CNT_W'(1);
            end
            WIN_APPEND:
            begin
                if (full)
                begin
                    // evict the oldest entry, append at the top
                    st_next = st_up;
                    pd_next = pd_ev;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CNT_W'(i) == count_reg)
                        begin
                            st_next[i] = stamp_hold;
                            pd_next[i] = fresh;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        stat.hit  = hit;
        stat.drop = full && ((|pend0) || new_hit0);
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            pd_reg    <= pd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/tpm_datapath.sv @@
// Datapath: input hold registers, both windows, saturating totals, result register.
// Depends on tpm_pkg and tpm_window.
module tpm_datapath
    import tpm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    input  logic [STAMP_W-1:0] stamp,
    input  logic               is_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               paired,
    output logic               dropped,
    output logic [TOTAL_W-1:0] pair_total,
    output logic [TOTAL_W-1:0] drop_total
);

    logic [STAMP_W-1:0] stamp_reg;
    logic               color_reg;
    win_op_t            color_op, depth_op;
    win_stat_t          color_stat, depth_stat;
    logic               hit, drop;
    logic [TOTAL_W-1:0] pair_cnt_reg, pair_cnt_next, drop_cnt_reg, drop_cnt_next;
    logic               out_valid_reg, paired_reg, dropped_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stamp_reg <= stamp;
            color_reg <= is_color;
        end
    end

    tpm_window #(.DEPTH(DEPTH)) u_color_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (cmd.capture),
        .stamp_in   (stamp),
        .stamp_hold (stamp_reg),
        .op         (color_op),
        .stat       (color_stat)
    );

    tpm_window #(.DEPTH(DEPTH)) u_depth_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (cmd.capture),
        .stamp_in   (stamp),
        .stamp_hold (stamp_reg),
        .op         (depth_op),
        .stat       (depth_stat)
    );

    always_comb
    begin
        hit  = color_reg ? depth_stat.hit : color_stat.hit;
        drop = !hit && (color_reg ? color_stat.drop : depth_stat.drop);
        color_op = WIN_HOLD;
        depth_op = WIN_HOLD;
        if (cmd.update)
        begin
            if (hit)
            begin
                // remove from the other side
                color_op = color_reg ? WIN_HOLD : WIN_REMOVE;
                depth_op = color_reg ? WIN_REMOVE : WIN_HOLD;
            end
            else
            begin
                color_op = color_reg ? WIN_APPEND : WIN_HOLD;
                depth_op = color_reg ? WIN_HOLD : WIN_APPEND;
            end
        end
        pair_cnt_next = pair_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        if (hit && pair_cnt_reg != TOTAL_MAX)
        begin
            pair_cnt_next = pair_cnt_reg + TOTAL_W'(1);
        end
        if (drop && drop_cnt_reg != TOTAL_MAX)
        begin
            drop_cnt_next = drop_cnt_reg + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_cnt_reg  <= '0;
            drop_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                pair_cnt_reg  <= pair_cnt_next;
                drop_cnt_reg  <= drop_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            paired_reg  <= hit;
            dropped_reg <= drop;
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign paired         = paired_reg;
    assign dropped        = dropped_reg;
    assign pair_total     = pair_cnt_reg;
    assign drop_total     = drop_cnt_reg;

endmodule

@@ hdl/tpm_ctrl.sv @@
// Controller: accept one item, then issue the window update when the result slot frees.
// Depends on tpm_pkg.
module tpm_ctrl
    import tpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (!stat.out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.update  = (state_reg == ST_UPDATE) && !stat.out_stall;

endmodule

@@ hdl/timestamp_pair_matcher.sv @@
// Top level of the timestamp pair matcher: controller plus datapath.
// Depends on tpm_pkg, tpm_ctrl, tpm_datapath (and tpm_window below it).
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | stamp[62:0], is_color
//  output  | out_valid / out_ready| paired, dropped, pair_total, drop_total
//
// For each item, the transfer edge compares the stamp against every entry
// of both windows in parallel and registers the match vectors; the update
// edge then updates one window (remove or append/evict) and loads the
// result register. One item is in flight at a time.
// While the result register is full and not taken, the update cycle holds.
// A new input transfer is taken while the previous result still waits.
// Reset clears both windows (fill counts, pending marks), totals and the FSM.
module timestamp_pair_matcher
    import tpm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [STAMP_W-1:0] stamp,
    input  logic               is_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               paired,
    output logic               dropped,
    output logic [TOTAL_W-1:0] pair_total,
    output logic [TOTAL_W-1:0] drop_total
);

    ctrl_cmd_t cmd;
    dp_stat_t  dp_stat;

    // sequencing: idle -> update, holding update while the result is stalled
    tpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (cmd)
    );

    // windows, totals and the result register
    tpm_datapath #(.DEPTH(WINDOW_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (dp_stat),
        .stamp      (stamp),
        .is_color   (is_color),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .paired     (paired),
        .dropped    (dropped),
        .pair_total (pair_total),
        .drop_total (drop_total)
    );

    // one item at a time: a transfer closes the input until its update
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is still in flight");

    // a pair removes from the other side and never appends, so no drop
    a_pair_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(paired && dropped))
        else $error("result shows both a pair and a drop");

    // an update always presents a result on the next cycle
    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid)
        else $error("update issued without a result");

    // a reported pair implies a nonzero pair total
    a_pair_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && paired) |-> (pair_total != '0))
        else $error("pair reported with zero pair total");

endmodule
